// ===== rtl/fbpa_pkg.sv =====
package fbpa_pkg;

  // Default sizing
  localparam int unsigned MaxBlocksDef   = 1024;
  localparam int unsigned HeaderBytesDef = 12;

  // Action codes
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_BADADDR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_SIZE  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SizeW    = 21;
  localparam int unsigned CountW   = 11;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] free_address;
  } fbpa_in_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } fbpa_out_t;

endpackage

// ===== rtl/fbpa_ram.sv =====
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// Steps: init writes one link per block; alloc does an IW-step shift-add multiply
//   (IW = index width) of index by block size, then adds base and header; free
//   does two subtracts, a 32-step restoring divide and a check, but stops after
//   them on a zero size; empty alloc and the unused action skip to the response.
// Throughput: one item at a time; the next is taken the cycle after the result
//   is queued, and a stalled result holds the block. Reset: asynchronous, active
//   low; free list empty, config at base 0, size 4, count 0. Links not cleared.
module fixed_block_pool_allocator_core
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbpa_in_t            in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fbpa_out_t           out_data_o
);

  // Index width holds the null index (= MAX_BLOCKS); link address width does not
  localparam int unsigned IW       = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LW       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned StepW    = 5;
  localparam int unsigned DivSteps = 32;
  localparam logic [IW-1:0] NullIdx = IW'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,      // chain links, one entry a cycle
    S_MUL,       // index * size, MSB first
    S_ADD_BASE,
    S_ADD_HDR,
    S_SUB_BASE,
    S_SUB_HDR,
    S_DIV,       // offset / size, one quotient bit a cycle
    S_CHECK,
    S_RESP
  } state_e;

  state_e            state_q;
  logic [31:0]       base_q;
  logic [SizeW-1:0]  size_q;
  logic [CountW-1:0] count_q;
  logic [IW-1:0]     head_q;
  logic [IW-1:0]     idx_q;
  logic [IW-1:0]     mplier_q;
  logic [StepW-1:0]  step_q;
  logic [31:0]       acc_q;
  logic [SizeW-1:0]  rem_q;
  fbpa_out_t         res_q;
  fbpa_out_t         out_q;
  logic              out_valid_q;

  // Shared 33-bit add/subtract unit: all address, multiply and divide steps
  logic [32:0] unit_a, unit_b, unit_res;
  logic        unit_sub;

  logic [IW-1:0]      eff_cnt;
  logic [IW-1:0]      idx_nxt;
  logic [SizeW:0]     rem_shift;
  logic               div_neg;
  logic               free_ok;
  logic               in_xfer;
  logic               out_free;

  logic               mem_we, mem_re;
  logic [LW-1:0]      mem_waddr;
  logic [IW-1:0]      mem_wdata;
  logic [IW-1:0]      mem_rdata;

  // Count clamped to the pool's capacity
  assign eff_cnt = (32'(count_q) > 32'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : IW'(count_q);
  assign idx_nxt = idx_q + IW'(1);

  assign rem_shift = {rem_q, acc_q[31]};
  assign div_neg   = unit_res[32];
  assign free_ok   = (rem_q == '0) && (acc_q < 32'(eff_cnt));

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unit_a   = {1'b0, acc_q};
    unit_b   = '0;
    unit_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        unit_a = {1'b0, acc_q[30:0], 1'b0};
        unit_b = mplier_q[IW-1] ? {12'b0, size_q} : '0;
      end
      S_ADD_BASE: unit_b = {1'b0, base_q};
      S_ADD_HDR:  unit_b = {1'b0, 32'(HEADER_BYTES)};
      S_SUB_BASE: begin
        unit_b   = {1'b0, base_q};
        unit_sub = 1'b1;
      end
      S_SUB_HDR: begin
        unit_b   = {1'b0, 32'(HEADER_BYTES)};
        unit_sub = 1'b1;
      end
      S_DIV: begin
        unit_a   = {11'b0, rem_shift};
        unit_b   = {12'b0, size_q};
        unit_sub = 1'b1;
      end
      default: begin
        unit_a   = {1'b0, acc_q};
        unit_b   = '0;
        unit_sub = 1'b0;
      end
    endcase
  end

  assign unit_res = unit_a + (unit_b ^ {33{unit_sub}}) + 33'(unit_sub);

  // Link memory: init and free write, alloc reads the head's link at transfer
  assign mem_we    = (state_q == S_INIT) || ((state_q == S_CHECK) && free_ok);
  assign mem_waddr = (state_q == S_INIT) ? idx_q[LW-1:0] : acc_q[LW-1:0];
  assign mem_wdata = (state_q == S_INIT) ? ((idx_nxt < eff_cnt) ? idx_nxt : NullIdx)
                                         : head_q;
  assign mem_re    = in_xfer && (in_data_i.action == ACT_ALLOC) && (head_q != NullIdx);

  fbpa_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_BLOCKS)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q[LW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      size_q      <= SizeW'(4);
      count_q     <= '0;
      head_q      <= NullIdx;
      idx_q       <= '0;
      mplier_q    <= '0;
      step_q      <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE:  base_q  <= cfg_wdata_i;
          CFG_SIZE:  size_q  <= cfg_wdata_i[SizeW-1:0];
          CFG_COUNT: count_q <= cfg_wdata_i[CountW-1:0];
          default:   ;
        endcase
      end

      // In S_RESP the output register is refilled below instead
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (in_data_i.action)
              ACT_INIT: begin
                res_q.block_address <= base_q;
                res_q.status        <= STAT_OK;
                idx_q               <= '0;
                if (eff_cnt == '0) begin
                  head_q  <= NullIdx;
                  state_q <= S_RESP;
                end else begin
                  state_q <= S_INIT;
                end
              end
              ACT_ALLOC: begin
                if (head_q == NullIdx) begin
                  res_q.block_address <= '0;
                  res_q.status        <= STAT_EMPTY;
                  state_q             <= S_RESP;
                end else begin
                  acc_q    <= '0;
                  mplier_q <= head_q;
                  step_q   <= StepW'(IW - 1);
                  state_q  <= S_MUL;
                end
              end
              ACT_FREE: begin
                acc_q   <= in_data_i.free_address;
                rem_q   <= '0;
                step_q  <= StepW'(DivSteps - 1);
                state_q <= S_SUB_BASE;
              end
              default: begin
                res_q.block_address <= '0;
                res_q.status        <= STAT_OK;
                state_q             <= S_RESP;
              end
            endcase
          end
        end
        S_INIT: begin
          idx_q <= idx_nxt;
          if (idx_nxt == eff_cnt) begin
            head_q  <= '0;
            state_q <= S_RESP;
          end
        end
        S_MUL: begin
          acc_q    <= unit_res[31:0];
          mplier_q <= mplier_q << 1;
          step_q   <= step_q - StepW'(1);
          if (step_q == '0) begin
            state_q <= S_ADD_BASE;
          end
        end
        S_ADD_BASE: begin
          acc_q   <= unit_res[31:0];
          head_q  <= mem_rdata;   // pop
          state_q <= S_ADD_HDR;
        end
        S_ADD_HDR: begin
          res_q.block_address <= unit_res[31:0];
          res_q.status        <= STAT_OK;
          state_q             <= S_RESP;
        end
        S_SUB_BASE: begin
          acc_q   <= unit_res[31:0];
          state_q <= S_SUB_HDR;
        end
        S_SUB_HDR: begin
          acc_q <= unit_res[31:0];
          if (size_q == '0) begin
            res_q.block_address <= '0;
            res_q.status        <= STAT_BADADDR;
            state_q             <= S_RESP;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= div_neg ? rem_shift[SizeW-1:0] : unit_res[SizeW-1:0];
          acc_q  <= {acc_q[30:0], ~div_neg};
          step_q <= step_q - StepW'(1);
          if (step_q == '0) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_q.block_address <= '0;
          if (free_ok) begin
            head_q       <= acc_q[IW-1:0];   // push
            res_q.status <= STAT_OK;
          end else begin
            res_q.status <= STAT_BADADDR;
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Head never points past the null index
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NullIdx)
    else $error("head index out of range");

  // An empty pool never returns an address
  a_empty_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == STAT_EMPTY)) |-> (out_data_o.block_address == '0))
    else $error("empty alloc with non-zero address");

  // Busy straight after a transfer in
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("request taken while idle after transfer");

  // Multiply step count stays within the index width
  a_mul_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (step_q < StepW'(IW)))
    else $error("multiply step out of range");

  // Links only written by init walk or accepted free
  a_link_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_INIT) || (state_q == S_CHECK)))
    else $error("unexpected link write");

endmodule
